/* rtl/hhc_pkg.sv */
// Package for the humidistat hysteresis controller.
// Holds config and item types, reset values, register indexes and the
// set point clamp and band helpers; no dependencies.
package hhc_pkg;

	localparam int TIMER_BITS_DEF = 16;
	localparam int PERIOD_W       = 16;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 16;
	localparam int SP_W           = 7;
	localparam int HYST_W         = 9;
	localparam int HUM_W          = 10;

	typedef enum logic [CFG_IDX_W-1:0] {
		IDX_SP_INIT,
		IDX_SP_MIN,
		IDX_SP_MAX,
		IDX_SP_STEP,
		IDX_HYST,
		IDX_BTN_PER,
		IDX_SMP_PER,
		IDX_CTL_PER
	} cfg_idx_t;

	typedef struct packed {
		logic [SP_W-1:0]     sp_init;
		logic [SP_W-1:0]     sp_min;
		logic [SP_W-1:0]     sp_max;
		logic [SP_W-1:0]     sp_step;
		logic [HYST_W-1:0]   hyst;
		logic [PERIOD_W-1:0] btn_per;
		logic [PERIOD_W-1:0] smp_per;
		logic [PERIOD_W-1:0] ctl_per;
	} cfg_t;

	typedef struct packed {
		logic signed [11:0] lo;
		logic [10:0]        hi;
	} band_t;

	typedef struct packed {
		logic [SP_W-1:0] sp;
		band_t           band;
	} init_t;

	typedef struct packed {
		logic             restart;
		logic             up;
		logic             down;
		logic [HUM_W-1:0] humidity;
		logic             ok;
	} tick_t;

	typedef struct packed {
		logic             relay;
		logic [SP_W-1:0]  sp;
		logic [HUM_W-1:0] hum;
		logic             vld;
	} res_t;

	localparam cfg_t CFG_RST = '{
		sp_init: 7'd55, sp_min: 7'd30, sp_max: 7'd90, sp_step: 7'd1,
		hyst: 9'd30, btn_per: 16'd30, smp_per: 16'd1200, ctl_per: 16'd100
	};

	// clamp(55) with 550 -/+ 30
	localparam init_t INIT_RST = '{sp: 7'd55, band: '{lo: 12'sd520, hi: 11'd580}};

	// below min wins over above max
	function automatic logic [SP_W-1:0] clamp_sp(input logic signed [8:0] v,
			input logic [SP_W-1:0] lo, input logic [SP_W-1:0] hi);
		logic [SP_W-1:0] r;
		if (v < $signed({2'b00, lo})) begin
			r = lo;
		end else if (v > $signed({2'b00, hi})) begin
			r = hi;
		end else begin
			r = v[SP_W-1:0];
		end
		return r;
	endfunction

	function automatic band_t make_band(input logic [SP_W-1:0] sp,
			input logic [HYST_W-1:0] hyst);
		logic [10:0] sp10;
		band_t b;
		sp10 = {1'b0, sp, 3'b000} + {3'b000, sp, 1'b0};
		b.lo = $signed({1'b0, sp10}) - $signed({3'b000, hyst});
		b.hi = sp10 + {2'b00, hyst};
		return b;
	endfunction

endpackage

/* rtl/hhc_timer.sv */
// Saturating elapsed-time counter for one scheduled task.
// Flags the task due and clears on the tick it runs; uses hhc_pkg.
module hhc_timer #(
	parameter int TIMER_BITS = hhc_pkg::TIMER_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic                         restart,
	input  logic [hhc_pkg::PERIOD_W-1:0] period,
	output logic                         due
);
	import hhc_pkg::*;

	localparam int CW = (TIMER_BITS > PERIOD_W) ? TIMER_BITS : PERIOD_W;
	localparam logic [TIMER_BITS-1:0] CNT_MAX = '1;

	logic [TIMER_BITS-1:0] cnt_q;
	logic [TIMER_BITS-1:0] base;
	logic [TIMER_BITS-1:0] inc;
	logic [TIMER_BITS-1:0] cnt_d;

	always_comb begin
		base  = restart ? CNT_MAX : cnt_q;
		inc   = (base == CNT_MAX) ? base : base + TIMER_BITS'(1);
		due   = (CW'(inc) >= CW'(period)) || (inc == CNT_MAX);
		cnt_d = due ? '0 : inc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= CNT_MAX;
		end else if (step) begin
			cnt_q <= cnt_d;
		end
	end

endmodule

/* rtl/hhc_cfg_regs.sv */
// Configuration register file and restart values derived from it.
// Precomputes the clamped initial set point and its band; uses hhc_pkg.
module hhc_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [hhc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hhc_pkg::CFG_DATA_W-1:0] cfg_data,
	output hhc_pkg::cfg_t                  cfg,
	output hhc_pkg::init_t                 init
);
	import hhc_pkg::*;

	cfg_t            cfg_q;
	init_t           init_q;
	logic [SP_W-1:0] init_sp;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;
	assign init      = init_q;
	assign init_sp   = clamp_sp({2'b00, cfg_q.sp_init}, cfg_q.sp_min, cfg_q.sp_max);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RST;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				IDX_SP_INIT: cfg_q.sp_init <= cfg_data[SP_W-1:0];
				IDX_SP_MIN:  cfg_q.sp_min  <= cfg_data[SP_W-1:0];
				IDX_SP_MAX:  cfg_q.sp_max  <= cfg_data[SP_W-1:0];
				IDX_SP_STEP: cfg_q.sp_step <= cfg_data[SP_W-1:0];
				IDX_HYST:    cfg_q.hyst    <= cfg_data[HYST_W-1:0];
				IDX_BTN_PER: cfg_q.btn_per <= cfg_data[PERIOD_W-1:0];
				IDX_SMP_PER: cfg_q.smp_per <= cfg_data[PERIOD_W-1:0];
				IDX_CTL_PER: cfg_q.ctl_per <= cfg_data[PERIOD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= INIT_RST;
		end else begin
			init_q <= '{sp: init_sp, band: make_band(init_sp, cfg_q.hyst)};
		end
	end

endmodule

/* rtl/hhc_core.sv */
// Controller state and the per-tick update: presses, set point, sample, relay.
// The state registers double as the result register; uses hhc_pkg, hhc_timer.
module hhc_core #(
	parameter int TIMER_BITS = hhc_pkg::TIMER_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  hhc_pkg::tick_t tick,
	input  hhc_pkg::cfg_t  cfg,
	input  hhc_pkg::init_t init,
	output hhc_pkg::res_t  res
);
	import hhc_pkg::*;

	logic [SP_W-1:0]  sp_q;
	band_t            band_q;
	logic [HUM_W-1:0] hum_q;
	logic             vld_q;
	logic             relay_q;
	logic [1:0]       pend_q;

	logic [SP_W-1:0]  sp_d;
	band_t            band_d;
	logic [HUM_W-1:0] hum_d;
	logic             vld_d;
	logic             relay_d;
	logic [1:0]       pend_d;

	logic btn_due;
	logic smp_due;
	logic ctl_due;

	hhc_timer #(.TIMER_BITS(TIMER_BITS)) u_btn_timer (
		.clk(clk), .arst_n(arst_n), .step(step), .restart(tick.restart),
		.period(cfg.btn_per), .due(btn_due)
	);

	hhc_timer #(.TIMER_BITS(TIMER_BITS)) u_smp_timer (
		.clk(clk), .arst_n(arst_n), .step(step), .restart(tick.restart),
		.period(cfg.smp_per), .due(smp_due)
	);

	hhc_timer #(.TIMER_BITS(TIMER_BITS)) u_ctl_timer (
		.clk(clk), .arst_n(arst_n), .step(step), .restart(tick.restart),
		.period(cfg.ctl_per), .due(ctl_due)
	);

	always_comb begin
		logic signed [8:0] moved;
		logic [1:0]        pend;
		moved = '0;
		if (tick.restart) begin
			sp_d    = init.sp;
			band_d  = init.band;
			hum_d   = '0;
			vld_d   = 1'b0;
			relay_d = 1'b0;
			pend    = '0;
		end else begin
			sp_d    = sp_q;
			band_d  = band_q;
			hum_d   = hum_q;
			vld_d   = vld_q;
			relay_d = relay_q;
			pend    = pend_q;
		end
		pend   = pend | {tick.down, tick.up};
		pend_d = pend;

		if (btn_due) begin
			pend_d = '0;
			if (pend != 2'b00) begin
				moved = $signed({2'b00, sp_d})
					+ (pend[0] ? $signed({2'b00, cfg.sp_step}) : 9'sd0)
					- (pend[1] ? $signed({2'b00, cfg.sp_step}) : 9'sd0);
				sp_d   = clamp_sp(moved, cfg.sp_min, cfg.sp_max);
				band_d = make_band(sp_d, cfg.hyst);
			end
		end

		if (smp_due) begin
			if (tick.ok) begin
				hum_d = tick.humidity;
				vld_d = 1'b1;
			end else begin
				vld_d = 1'b0;
			end
		end

		if (ctl_due && vld_d) begin
			if (!relay_d && ($signed({2'b00, hum_d}) < band_d.lo)) begin
				relay_d = 1'b1;
			end else if (relay_d && ({1'b0, hum_d} > band_d.hi)) begin
				relay_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q    <= INIT_RST.sp;
			band_q  <= INIT_RST.band;
			hum_q   <= '0;
			vld_q   <= 1'b0;
			relay_q <= 1'b0;
			pend_q  <= '0;
		end else if (step) begin
			sp_q    <= sp_d;
			band_q  <= band_d;
			hum_q   <= hum_d;
			vld_q   <= vld_d;
			relay_q <= relay_d;
			pend_q  <= pend_d;
		end
	end

	assign res = '{relay: relay_q, sp: sp_q, hum: hum_q, vld: vld_q};

	a_band_order: assert property (@(posedge clk) disable iff (!arst_n)
		$signed({1'b0, band_q.hi}) >= band_q.lo)
		else $error("upper threshold below lower threshold");

	a_relay_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(relay_q) && $stable(sp_q) && $stable(hum_q))
		else $error("result state moved without an item");

	a_relay_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(relay_q) |-> vld_q)
		else $error("relay turned on without valid humidity");

	a_pend_clear: assert property (@(posedge clk) disable iff (!arst_n)
		step && btn_due |=> pend_q == 2'b00)
		else $error("pending presses kept after button poll");

endmodule

/* rtl/humidistat_hysteresis_controller_unit.sv */
// Humidistat hysteresis controller, one item per millisecond tick.
// An accepted item waits in the input register until the result register is free, then updates it.
// One item per cycle while results are taken; a waiting result holds a filled input register.
// The state registers serve as the result register and update only when it is free.
// Reset: asynchronous, loads register defaults, set point 55 and all tasks due.
// Depends on hhc_pkg, hhc_cfg_regs, hhc_core.
module humidistat_hysteresis_controller_unit #(
	parameter int TIMER_BITS = hhc_pkg::TIMER_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [hhc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hhc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           restart,
	input  logic                           up_press,
	input  logic                           down_press,
	input  logic [hhc_pkg::HUM_W-1:0]      humidity_sample,
	input  logic                           sample_ok,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           relay_on,
	output logic [hhc_pkg::SP_W-1:0]       setpoint_now,
	output logic [hhc_pkg::HUM_W-1:0]      humidity_held,
	output logic                           humidity_valid
);
	import hhc_pkg::*;

	cfg_t  cfg;
	init_t init;
	tick_t tick_s1;
	logic  vld_s1;
	logic  out_valid_q;
	logic  step;
	res_t  res;

	hhc_cfg_regs u_cfg (
		.clk(clk), .arst_n(arst_n), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .cfg(cfg), .init(init)
	);

	assign step     = vld_s1 && (!out_valid_q || out_ready);
	assign in_ready = !vld_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				vld_s1 <= in_valid;
			end
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			tick_s1 <= '{restart: restart, up: up_press, down: down_press,
				humidity: humidity_sample, ok: sample_ok};
		end
	end

	hhc_core #(.TIMER_BITS(TIMER_BITS)) u_core (
		.clk(clk), .arst_n(arst_n), .step(step), .tick(tick_s1),
		.cfg(cfg), .init(init), .res(res)
	);

	assign out_valid      = out_valid_q;
	assign relay_on       = res.relay;
	assign setpoint_now   = res.sp;
	assign humidity_held  = res.hum;
	assign humidity_valid = res.vld;

endmodule

/* tb/sv/tb_humidistat_hysteresis_controller_unit.sv */
`timescale 1ns / 100ps
// Self-checking testbench for humidistat_hysteresis_controller_unit: directed and random ticks,
// with every result checked against an in-bench humidistat predictor.
// Depends on hhc_pkg and the controller RTL only.
module tb_humidistat_hysteresis_controller_unit;
	import hhc_pkg::*;

	typedef struct {
		logic            relay;
		logic [SP_W-1:0] sp;
		logic [HUM_W-1:0] hum;
		logic            vld;
	} reading_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic                  restart;
	logic                  up_press;
	logic                  down_press;
	logic [HUM_W-1:0]      humidity_sample;
	logic                  sample_ok;
	logic                  out_valid;
	logic                  out_ready;
	logic                  relay_on;
	logic [SP_W-1:0]       setpoint_now;
	logic [HUM_W-1:0]      humidity_held;
	logic                  humidity_valid;

	// register settings mirrored by the predictor
	logic [SP_W-1:0]     sp_initial, sp_floor, sp_ceiling, sp_step;
	logic [HYST_W-1:0]   hyst_tenths;
	logic [PERIOD_W-1:0] button_period, sample_period, control_period;

	// controller state mirrored by the predictor
	logic [SP_W-1:0]     setpoint;
	logic signed [12:0]  band_lo, band_hi;
	logic [HUM_W-1:0]    humidity;
	logic                humidity_ok, relay;
	logic [PERIOD_W-1:0] button_age, sample_age, control_age;
	logic                up_pending, down_pending;

	reading_t            expected_readings[$];
	logic [CFG_DATA_W-1:0] reg_image[8];
	int                  mismatch_count;
	int                  sender_idle_pct;
	int                  receiver_idle_pct;

	humidistat_hysteresis_controller_unit u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.restart        (restart),
		.up_press       (up_press),
		.down_press     (down_press),
		.humidity_sample(humidity_sample),
		.sample_ok      (sample_ok),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.relay_on       (relay_on),
		.setpoint_now   (setpoint_now),
		.humidity_held  (humidity_held),
		.humidity_valid (humidity_valid)
	);

	always #5 clk = ~clk;

	function automatic logic [SP_W-1:0] clamp_setpoint(input int v);
		if (v < int'(sp_floor)) begin
			return sp_floor;
		end else if (v > int'(sp_ceiling)) begin
			return sp_ceiling;
		end
		return v[SP_W-1:0];
	endfunction

	function automatic void recompute_band();
		int center;
		center = int'(setpoint) * 10;
		band_lo = 13'(center - int'(hyst_tenths));
		band_hi = 13'(center + int'(hyst_tenths));
	endfunction

	function automatic void restart_controller();
		setpoint = clamp_setpoint(int'(sp_initial));
		recompute_band();
		humidity = '0;
		humidity_ok = 1'b0;
		relay = 1'b0;
		button_age = '1;
		sample_age = '1;
		control_age = '1;
		up_pending = 1'b0;
		down_pending = 1'b0;
	endfunction

	// saturating increment; the task is due at its period or at saturation
	function automatic logic [PERIOD_W-1:0] age_tick(input logic [PERIOD_W-1:0] age);
		return (age == '1) ? age : age + PERIOD_W'(1);
	endfunction

	function automatic logic age_due(input logic [PERIOD_W-1:0] age,
			input logic [PERIOD_W-1:0] period);
		return (age >= period) || (age == '1);
	endfunction

	function automatic reading_t humidistat_next(input logic rst, input logic up,
			input logic dn, input logic [HUM_W-1:0] hum_in, input logic ok);
		int       target;
		logic     moved;
		reading_t r;
		if (rst) restart_controller();
		if (up) up_pending = 1'b1;
		if (dn) down_pending = 1'b1;

		button_age = age_tick(button_age);
		if (age_due(button_age, button_period)) begin
			button_age = '0;
			target = int'(setpoint);
			moved = 1'b0;
			if (up_pending) begin
				target = target + int'(sp_step);
				moved = 1'b1;
			end
			if (down_pending) begin
				target = target - int'(sp_step);
				moved = 1'b1;
			end
			up_pending = 1'b0;
			down_pending = 1'b0;
			if (moved) begin
				setpoint = clamp_setpoint(target);
				recompute_band();
			end
		end

		sample_age = age_tick(sample_age);
		if (age_due(sample_age, sample_period)) begin
			sample_age = '0;
			if (ok) begin
				humidity = hum_in;
				humidity_ok = 1'b1;
			end else begin
				humidity_ok = 1'b0;
			end
		end

		control_age = age_tick(control_age);
		if (age_due(control_age, control_period)) begin
			control_age = '0;
			if (humidity_ok) begin
				if (!relay && int'(humidity) < int'(band_lo)) begin
					relay = 1'b1;
				end else if (relay && int'(humidity) > int'(band_hi)) begin
					relay = 1'b0;
				end
			end
		end

		r.relay = relay;
		r.sp = setpoint;
		r.hum = humidity;
		r.vld = humidity_ok;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// check results, mirror register writes, predict accepted items
	always @(posedge clk) begin
		reading_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_readings.size() == 0) begin
					report_mismatch("unexpected result, setpoint", int'(setpoint_now), 0);
				end else begin
					want = expected_readings.pop_front();
					if (relay_on !== want.relay)
						report_mismatch("relay_on", int'(relay_on), int'(want.relay));
					if (setpoint_now !== want.sp)
						report_mismatch("setpoint_now", int'(setpoint_now), int'(want.sp));
					if (humidity_held !== want.hum)
						report_mismatch("humidity_held", int'(humidity_held),
								int'(want.hum));
					if (humidity_valid !== want.vld)
						report_mismatch("humidity_valid", int'(humidity_valid),
								int'(want.vld));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					IDX_SP_INIT: sp_initial = cfg_data[SP_W-1:0];
					IDX_SP_MIN:  sp_floor = cfg_data[SP_W-1:0];
					IDX_SP_MAX:  sp_ceiling = cfg_data[SP_W-1:0];
					IDX_SP_STEP: sp_step = cfg_data[SP_W-1:0];
					IDX_HYST:    hyst_tenths = cfg_data[HYST_W-1:0];
					IDX_BTN_PER: button_period = cfg_data[PERIOD_W-1:0];
					IDX_SMP_PER: sample_period = cfg_data[PERIOD_W-1:0];
					IDX_CTL_PER: control_period = cfg_data[PERIOD_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				expected_readings.push_back(humidistat_next(restart, up_press, down_press,
						humidity_sample, sample_ok));
		end
	end

	always @(negedge clk) begin
		out_ready = ($urandom_range(99) >= receiver_idle_pct);
	end

	task automatic send_tick(input logic rst, input logic up, input logic dn,
			input logic [HUM_W-1:0] hum_in, input logic ok);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		restart = rst;
		up_press = up;
		down_press = dn;
		humidity_sample = hum_in;
		sample_ok = ok;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// hold input until every expected result is back, then let the pipe settle
	task automatic wait_idle();
		in_valid = 1'b0;
		while (expected_readings.size() != 0) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic load_registers();
		for (int i = 0; i < 8; i++) begin
			cfg_valid = 1'b1;
			cfg_index = cfg_idx_t'(i);
			cfg_data = reg_image[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			@(negedge clk);
		end
		cfg_valid = 1'b0;
	endtask

	function automatic logic [PERIOD_W-1:0] random_period();
		case ($urandom_range(19))
			0:       return '1;
			1:       return '0;
			2, 3, 4: return PERIOD_W'($urandom_range(40, 7));
			default: return PERIOD_W'($urandom_range(6, 1));
		endcase
	endfunction

	task automatic test_power_on_defaults();
		send_tick(1'b0, 1'b1, 1'b0, 10'd0, 1'b1);
		send_tick(1'b0, 1'b0, 1'b1, 10'd1023, 1'b1);
		send_tick(1'b0, 1'b1, 1'b1, 10'd512, 1'b0);
		send_tick(1'b1, 1'b0, 1'b0, 10'd700, 1'b1);
		wait_idle();
	endtask

	task automatic test_register_extremes();
		// floor above ceiling, widest band, tasks every tick
		reg_image = '{16'd127, 16'd100, 16'd0, 16'd127, 16'd511, 16'd0, 16'd0, 16'd0};
		load_registers();
		send_tick(1'b1, 1'b1, 1'b1, 10'd1023, 1'b1);
		send_tick(1'b0, 1'b0, 1'b0, 10'd0, 1'b1);
		send_tick(1'b0, 1'b1, 1'b0, 10'd1023, 1'b0);
		send_tick(1'b0, 1'b0, 1'b1, 10'd1000, 1'b1);
		wait_idle();
		// zero band, longest periods against a sample every tick
		reg_image = '{16'd0, 16'd0, 16'd127, 16'd127, 16'd0, 16'hFFFF, 16'd1, 16'hFFFF};
		load_registers();
		send_tick(1'b1, 1'b1, 1'b0, 10'd1023, 1'b1);
		send_tick(1'b0, 1'b0, 1'b0, 10'd0, 1'b1);
		send_tick(1'b0, 1'b0, 1'b1, 10'd1001, 1'b1);
		send_tick(1'b0, 1'b1, 1'b0, 10'd1023, 1'b1);
		wait_idle();
	endtask

	task automatic test_press_latching();
		reg_image = '{16'd50, 16'd30, 16'd90, 16'd5, 16'd20, 16'd3, 16'd2, 16'd1};
		load_registers();
		send_tick(1'b1, 1'b0, 1'b0, 10'd500, 1'b1);
		send_tick(1'b0, 1'b1, 1'b0, 10'd470, 1'b1);
		send_tick(1'b0, 1'b1, 1'b0, 10'd480, 1'b1);
		send_tick(1'b0, 1'b0, 1'b0, 10'd560, 1'b1);
		send_tick(1'b0, 1'b0, 1'b1, 10'd580, 1'b0);
		send_tick(1'b0, 1'b1, 1'b1, 10'd600, 1'b1);
		send_tick(1'b1, 1'b0, 1'b1, 10'd400, 1'b1);
		wait_idle();
	endtask

	task automatic test_random_ticks(input int n_items);
		int   sent;
		int   seg_len;
		int   level;
		logic rst;
		logic ok;
		logic [HUM_W-1:0] hum_in;
		sent = 0;
		while (sent < n_items) begin
			wait_idle();
			reg_image[IDX_SP_INIT] = CFG_DATA_W'(($urandom_range(9) == 0) ?
					$urandom_range(127) : $urandom_range(100));
			if ($urandom_range(5) == 0) begin
				reg_image[IDX_SP_MIN] = CFG_DATA_W'($urandom_range(127));
				reg_image[IDX_SP_MAX] = CFG_DATA_W'($urandom_range(127));
			end else begin
				reg_image[IDX_SP_MIN] = CFG_DATA_W'($urandom_range(60));
				reg_image[IDX_SP_MAX] = CFG_DATA_W'($urandom_range(100,
						int'(reg_image[IDX_SP_MIN])));
			end
			reg_image[IDX_SP_STEP] = CFG_DATA_W'(($urandom_range(7) == 0) ?
					$urandom_range(127) : $urandom_range(12));
			reg_image[IDX_HYST] = CFG_DATA_W'(($urandom_range(3) == 0) ?
					$urandom_range(511) : $urandom_range(60));
			reg_image[IDX_BTN_PER] = random_period();
			reg_image[IDX_SMP_PER] = random_period();
			reg_image[IDX_CTL_PER] = random_period();
			load_registers();
			seg_len = $urandom_range(50, 15);
			for (int k = 0; k < seg_len; k++) begin
				rst = (k == 0) ? ($urandom_range(3) != 0) : ($urandom_range(49) == 0);
				ok = ($urandom_range(99) < 85);
				case ($urandom_range(9))
					0, 1: hum_in = HUM_W'($urandom_range(1023));
					2:    hum_in = HUM_W'($urandom_range(1023, 1000));
					default: begin
						// aim at the band edges of the current set point
						level = int'(setpoint) * 10 + $urandom_range(2 * int'(hyst_tenths) + 30)
								- int'(hyst_tenths) - 15;
						if (level < 0) level = 0;
						if (level > 1023) level = 1023;
						hum_in = level[HUM_W-1:0];
					end
				endcase
				send_tick(rst, ($urandom_range(99) < 30), ($urandom_range(99) < 30), hum_in, ok);
				sent++;
			end
		end
		wait_idle();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		restart = 1'b0;
		up_press = 1'b0;
		down_press = 1'b0;
		humidity_sample = '0;
		sample_ok = 1'b0;
		out_ready = 1'b0;
		mismatch_count = 0;
		sender_idle_pct = 12;
		receiver_idle_pct = 63;
		sp_initial = 7'd55;
		sp_floor = 7'd30;
		sp_ceiling = 7'd90;
		sp_step = 7'd1;
		hyst_tenths = 9'd30;
		button_period = 16'd30;
		sample_period = 16'd1200;
		control_period = 16'd100;
		restart_controller();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_power_on_defaults();
		test_register_extremes();
		test_press_latching();
		test_random_ticks(216);
		sender_idle_pct = 63;
		receiver_idle_pct = 12;
		test_random_ticks(216);
		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		test_random_ticks(216);
		wait_idle();

		if (mismatch_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
